[rtl/utx_pkg.sv]
// utx_pkg: shared constants, job type and unit encoder for the transcoder.
// Used by utx_front, utx_queue, utx_back and unicode_transcoder_top.
package utx_pkg;

    // encoding codes (src_encoding / dst_encoding)
    localparam logic [1:0] ENC_ASCII = 2'd0;
    localparam logic [1:0] ENC_UTF8  = 2'd1;
    localparam logic [1:0] ENC_UTF16 = 2'd2;
    localparam logic [1:0] ENC_UTF32 = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SRC    = 2'd0;
    localparam logic [1:0] CFG_DST    = 2'd1;
    localparam logic [1:0] CFG_STRICT = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ASCII = 3'd1;
    localparam logic [2:0] ST_BAD_UTF8  = 3'd2;
    localparam logic [2:0] ST_BAD_UTF16 = 3'd3;
    localparam logic [2:0] ST_BAD_UTF32 = 3'd4;
    localparam logic [2:0] ST_UNENC     = 3'd5;

    localparam logic [20:0] SUBST_CP = 21'h3F;

    localparam int UTX_QUEUE_DEPTH = 4;

    // One decoded input item: an error, or one or two code points.
    typedef struct packed {
        logic        err;
        logic [2:0]  code;
        logic        two;
        logic [20:0] cp0;
        logic [1:0]  len0_m1;
        logic [20:0] cp1;
        logic [1:0]  len1_m1;
        logic        eos;
    } job_t;

    // number of destination units minus one
    function automatic logic [1:0] enc_len(logic [20:0] cp, logic [1:0] dst);
        logic [1:0] len;
        len = 2'd0;
        if (dst == ENC_UTF8) begin
            if (cp < 21'h80)         len = 2'd0;
            else if (cp < 21'h800)   len = 2'd1;
            else if (cp < 21'h10000) len = 2'd2;
            else                     len = 2'd3;
        end else if (dst == ENC_UTF16) begin
            len = (cp > 21'hFFFF) ? 2'd1 : 2'd0;
        end
        return len;
    endfunction

    // unit k of the encoding of cp
    function automatic logic [31:0] enc_unit(logic [20:0] cp, logic [1:0] dst,
                                             logic [1:0] len_m1, logic [1:0] k);
        logic [1:0]  sh;
        logic [20:0] part;
        logic [7:0]  oct;
        logic [15:0] half;
        logic [31:0] unit;
        sh = len_m1 - k;
        case (sh)
            2'd0:    part = cp;
            2'd1:    part = cp >> 6;
            2'd2:    part = cp >> 12;
            default: part = cp >> 18;
        endcase
        unit = {11'd0, cp};
        if (dst == ENC_UTF8 && len_m1 != 2'd0) begin
            if (k == 2'd0) begin
                case (len_m1)
                    2'd1:    oct = 8'hC0 | {3'd0, part[4:0]};
                    2'd2:    oct = 8'hE0 | {4'd0, part[3:0]};
                    default: oct = 8'hF0 | {5'd0, part[2:0]};
                endcase
            end else begin
                oct = 8'h80 | {2'd0, part[5:0]};
            end
            unit = {24'd0, oct};
        end else if (dst == ENC_UTF16 && len_m1 != 2'd0) begin
            if (k == 2'd0) half = {5'd0, cp[20:10]} + 16'hD7C0;
            else           half = {6'd0, cp[9:0]} + 16'hDC00;
            unit = {16'd0, half};
        end
        return unit;
    endfunction

endpackage

[rtl/utx_front.sv]
// utx_front: configuration registers, source decoding and error policy.
// Turns each accepted unit into at most one job; depends on utx_pkg.
module utx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [1:0]        cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              push,
    output utx_pkg::job_t     job,
    output logic [1:0]        dst_encoding
);
    import utx_pkg::*;

    typedef struct packed {
        logic        valid;
        logic        bad;
        logic [2:0]  code;
        logic [20:0] cp;
    } ev_t;

    typedef struct packed {
        ev_t         ev;
        logic [20:0] acc;
        logic [1:0]  rem;
        logic [2:0]  len;
    } lead8_t;

    typedef struct packed {
        ev_t         ev;
        logic [9:0]  lb;
        logic        lp;
    } lead16_t;

    function automatic ev_t mk_cp(logic [20:0] cp);
        ev_t e;
        e = '0;
        e.valid = 1'b1;
        e.cp = cp;
        return e;
    endfunction

    function automatic ev_t mk_bad(logic [2:0] code);
        ev_t e;
        e = '0;
        e.valid = 1'b1;
        e.bad = 1'b1;
        e.code = code;
        return e;
    endfunction

    function automatic logic cp_ok(logic [31:0] cp);
        return cp <= 32'h10FFFF && (cp < 32'hD800 || cp > 32'hDFFF);
    endfunction

    function automatic lead8_t utf8_lead(logic [7:0] b);
        lead8_t r;
        r = '0;
        if (!b[7])                 r.ev = mk_cp({13'd0, b});
        else if (b[7:5] == 3'b110) begin r.acc = {16'd0, b[4:0]}; r.rem = 2'd1; r.len = 3'd2; end
        else if (b[7:4] == 4'b1110) begin r.acc = {17'd0, b[3:0]}; r.rem = 2'd2; r.len = 3'd3; end
        else if (b[7:3] == 5'b11110) begin r.acc = {18'd0, b[2:0]}; r.rem = 2'd3; r.len = 3'd4; end
        else                       r.ev = mk_bad(ST_BAD_UTF8);
        return r;
    endfunction

    function automatic lead16_t utf16_first(logic [15:0] u);
        lead16_t r;
        r = '0;
        if (u[15:10] == 6'b110110) begin r.lb = u[9:0]; r.lp = 1'b1; end
        else if (u[15:10] == 6'b110111) r.ev = mk_bad(ST_BAD_UTF16);
        else r.ev = mk_cp({5'd0, u});
        return r;
    endfunction

    logic [1:0]  src_reg, src_next, dst_reg, dst_next;
    logic        strict_reg, strict_next;
    logic [20:0] seq_accum_reg, seq_accum_next;
    logic [1:0]  seq_rem_reg, seq_rem_next;
    logic [2:0]  seq_len_reg, seq_len_next;
    logic [9:0]  lead_bits_reg, lead_bits_next;
    logic        lead_pend_reg, lead_pend_next;
    logic        aborted_reg, aborted_next;

    logic        s_accept;
    ev_t         ev0, ev1;
    lead8_t      l8;
    lead16_t     f16;
    logic [20:0] d_acc, acc_shift, cp_pair, min_cp;
    logic [1:0]  d_rem;
    logic [2:0]  d_len;
    logic [9:0]  d_lb;
    logic        d_lp;
    logic        err0, err1, failed;
    logic [2:0]  code0, code1;
    logic [20:0] cp0_m, cp1_m;

    assign s_tready     = !q_full;
    assign s_accept     = s_tvalid && s_tready;
    assign dst_encoding = dst_reg;

    // decode one unit against the partial state
    always_comb
    begin
        ev0 = '0;
        ev1 = '0;
        d_acc = seq_accum_reg;
        d_rem = seq_rem_reg;
        d_len = seq_len_reg;
        d_lb  = lead_bits_reg;
        d_lp  = lead_pend_reg;
        l8  = utf8_lead(s_tdata[7:0]);
        f16 = utf16_first(s_tdata[15:0]);
        acc_shift = {seq_accum_reg[14:0], s_tdata[5:0]};
        cp_pair   = 21'h10000 + {1'b0, lead_bits_reg, s_tdata[9:0]};
        case (seq_len_reg)
            3'd2:    min_cp = 21'h80;
            3'd3:    min_cp = 21'h800;
            default: min_cp = 21'h10000;
        endcase
        case (src_reg)
            ENC_ASCII:
            begin
                if (s_tdata[7]) ev0 = mk_bad(ST_BAD_ASCII);
                else            ev0 = mk_cp({14'd0, s_tdata[6:0]});
            end
            ENC_UTF8:
            begin
                if (seq_rem_reg == 2'd0)
                begin
                    ev0 = l8.ev;
                    d_acc = l8.acc; d_rem = l8.rem; d_len = l8.len;
                end
                else if (s_tdata[7:6] == 2'b10)
                begin
                    if (seq_rem_reg == 2'd1)
                    begin
                        d_acc = '0; d_rem = 2'd0; d_len = 3'd0;
                        if (!cp_ok({11'd0, acc_shift}) || acc_shift < min_cp)
                            ev0 = mk_bad(ST_BAD_UTF8);
                        else
                            ev0 = mk_cp(acc_shift);
                    end
                    else
                    begin
                        d_acc = acc_shift;
                        d_rem = seq_rem_reg - 2'd1;
                    end
                end
                else
                begin
                    // broken sequence: substitute, then retry the byte as a lead
                    ev0 = mk_bad(ST_BAD_UTF8);
                    ev1 = l8.ev;
                    d_acc = l8.acc; d_rem = l8.rem; d_len = l8.len;
                end
                if (s_tlast && d_rem != 2'd0)
                begin
                    if (ev0.valid) ev1 = mk_bad(ST_BAD_UTF8);
                    else           ev0 = mk_bad(ST_BAD_UTF8);
                end
            end
            ENC_UTF16:
            begin
                if (!lead_pend_reg)
                begin
                    ev0 = f16.ev;
                    d_lb = f16.lb; d_lp = f16.lp;
                end
                else if (s_tdata[15:10] == 6'b110111)
                begin
                    ev0 = mk_cp(cp_pair);
                    d_lb = '0; d_lp = 1'b0;
                end
                else
                begin
                    ev0 = mk_bad(ST_BAD_UTF16);
                    ev1 = f16.ev;
                    d_lb = f16.lb; d_lp = f16.lp;
                end
                if (s_tlast && d_lp)
                begin
                    if (ev0.valid) ev1 = mk_bad(ST_BAD_UTF16);
                    else           ev0 = mk_bad(ST_BAD_UTF16);
                end
            end
            default:
            begin
                if (cp_ok(s_tdata)) ev0 = mk_cp(s_tdata[20:0]);
                else                ev0 = mk_bad(ST_BAD_UTF32);
            end
        endcase
    end

    // substitute or fail; ascii destination cannot carry cp above 0x7f
    always_comb
    begin
        err0  = ev0.valid && (ev0.bad || (dst_reg == ENC_ASCII && ev0.cp > 21'h7F));
        err1  = ev1.valid && (ev1.bad || (dst_reg == ENC_ASCII && ev1.cp > 21'h7F));
        code0 = ev0.bad ? ev0.code : ST_UNENC;
        code1 = ev1.bad ? ev1.code : ST_UNENC;
        failed = strict_reg && (err0 || err1);
        cp0_m = err0 ? SUBST_CP : ev0.cp;
        cp1_m = err1 ? SUBST_CP : ev1.cp;
        job.err     = failed;
        job.code    = err0 ? code0 : code1;
        job.two     = ev1.valid && !failed;
        job.cp0     = cp0_m;
        job.len0_m1 = enc_len(cp0_m, dst_reg);
        job.cp1     = cp1_m;
        job.len1_m1 = enc_len(cp1_m, dst_reg);
        job.eos     = s_tlast;
        push = s_accept && !aborted_reg && (failed || ev0.valid);
    end

    always_comb
    begin
        src_next = src_reg;
        dst_next = dst_reg;
        strict_next = strict_reg;
        seq_accum_next = seq_accum_reg;
        seq_rem_next   = seq_rem_reg;
        seq_len_next   = seq_len_reg;
        lead_bits_next = lead_bits_reg;
        lead_pend_next = lead_pend_reg;
        aborted_next   = aborted_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC:    src_next = cfg_data;
                CFG_DST:    dst_next = cfg_data;
                CFG_STRICT: strict_next = cfg_data[0];
                default:    ;
            endcase
            if (cfg_index == CFG_SRC || cfg_index == CFG_DST || cfg_index == CFG_STRICT)
            begin
                seq_accum_next = '0; seq_rem_next = '0; seq_len_next = '0;
                lead_bits_next = '0; lead_pend_next = 1'b0;
            end
        end
        else if (s_accept)
        begin
            if (aborted_reg)
            begin
                if (s_tlast) aborted_next = 1'b0;
            end
            else
            begin
                seq_accum_next = d_acc; seq_rem_next = d_rem; seq_len_next = d_len;
                lead_bits_next = d_lb;  lead_pend_next = d_lp;
                if (failed || s_tlast)
                begin
                    seq_accum_next = '0; seq_rem_next = '0; seq_len_next = '0;
                    lead_bits_next = '0; lead_pend_next = 1'b0;
                end
                if (failed && !s_tlast) aborted_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= ENC_UTF8;
            dst_reg <= ENC_UTF8;
            strict_reg <= 1'b0;
            seq_accum_reg <= '0;
            seq_rem_reg <= '0;
            seq_len_reg <= '0;
            lead_bits_reg <= '0;
            lead_pend_reg <= 1'b0;
            aborted_reg <= 1'b0;
        end
        else
        begin
            src_reg <= src_next;
            dst_reg <= dst_next;
            strict_reg <= strict_next;
            seq_accum_reg <= seq_accum_next;
            seq_rem_reg <= seq_rem_next;
            seq_len_reg <= seq_len_next;
            lead_bits_reg <= lead_bits_next;
            lead_pend_reg <= lead_pend_next;
            aborted_reg <= aborted_next;
        end
    end

    a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg |-> (seq_rem_reg == 2'd0 && !lead_pend_reg))
        else $error("partial state kept across abort");
    a_partial_src: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_rem_reg == 2'd0 || src_reg == ENC_UTF8) &&
        (!lead_pend_reg || src_reg == ENC_UTF16))
        else $error("partial state does not match source encoding");
    a_no_push_aborted: assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg |-> !push)
        else $error("job issued inside aborted string");

endmodule

[rtl/utx_queue.sv]
// utx_queue: short job queue between decoder and encoder.
// Register-based FIFO of utx_pkg::job_t entries.
module utx_queue #(
    parameter int DEPTH = utx_pkg::UTX_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  utx_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output utx_pkg::job_t head
);
    import utx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/utx_back.sv]
// utx_back: expands queued jobs into destination units, one per cycle unless
// stalled by m_tready, into a registered output stage. Depends on utx_pkg.
module utx_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    dst_encoding,
    input  logic          head_valid,
    input  utx_pkg::job_t head,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,
    output logic [3:0]    m_tuser,
    output logic          m_tlast
);
    import utx_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_unit_reg;
    logic [2:0]  out_status_reg;
    logic        out_run_last_reg, out_done_reg;

    logic [2:0]  len0, len1, last_idx, idx_w;
    logic        second, is_last, load;
    logic [20:0] cp_sel;
    logic [1:0]  lm1_sel, k_sel;
    logic [31:0] unit_w;

    always_comb
    begin
        len0  = {1'b0, head.len0_m1} + 3'd1;
        len1  = {1'b0, head.len1_m1} + 3'd1;
        idx_w = {1'b0, idx_reg};
        if (head.err)      last_idx = 3'd0;
        else if (head.two) last_idx = len0 + len1 - 3'd1;
        else               last_idx = len0 - 3'd1;
        second  = head.two && (idx_w >= len0);
        cp_sel  = second ? head.cp1 : head.cp0;
        lm1_sel = second ? head.len1_m1 : head.len0_m1;
        k_sel   = second ? 2'(idx_w - len0) : idx_reg;
        unit_w  = head.err ? 32'd0 : enc_unit(cp_sel, dst_encoding, lm1_sel, k_sel);
        is_last = (idx_w == last_idx);
        load    = head_valid && (!out_valid_reg || m_tready);
        pop     = load && is_last;
        idx_next = idx_reg;
        if (load) idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
        out_valid_next = out_valid_reg;
        if (load)          out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_unit_reg     <= unit_w;
            out_status_reg   <= head.err ? head.code : ST_OK;
            out_run_last_reg <= is_last;
            out_done_reg     <= is_last && (head.eos || head.err);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_unit_reg;
    assign m_tuser  = {out_run_last_reg, out_status_reg};
    assign m_tlast  = out_done_reg;

    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |->
        (out_run_last_reg && out_done_reg && out_unit_reg == 32'd0))
        else $error("error transaction not alone or nonzero");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> out_run_last_reg)
        else $error("string end without run end");
    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0)
        else $error("unit index not rewound after job");

endmodule

[rtl/unicode_transcoder_top.sv]
// unicode_transcoder_top: streaming UTF transcoder, top level.
// Instantiates utx_front, utx_queue and utx_back; depends on utx_pkg.
//
// Converts a stream of source code units (ASCII, UTF-8, UTF-16 or UTF-32)
// into destination code units of any of those encodings. The front end takes
// one source unit per cycle, decodes it against the partial UTF-8 sequence or
// pending lead surrogate, applies the substitute/strict policy and queues a
// job of one or two code points, or one error. The back end, unless stalled,
// emits one destination unit per cycle from the head job through a registered
// output stage, so a job yields one to four units (four for a substitution
// followed by a three-byte UTF-8 character). Sustained input rate is one unit
// per cycle while each unit yields at most one output transaction; longer
// runs are absorbed by the QUEUE_DEPTH-entry job queue, and s_tready drops
// only when that queue is full. Units that yield nothing (a UTF-8 lead or
// continuation, a lead surrogate, dropped units of an aborted string) never
// enter the queue. Configuration writes must be made while the block is idle;
// any write to a defined register clears the partial decode state.
module unicode_transcoder_top #(
    parameter int QUEUE_DEPTH = utx_pkg::UTX_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: 0 src_encoding, 1 dst_encoding, 2 strict_mode
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    // source stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] code_unit
    input  logic        s_tlast,   // end_of_string
    // destination stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] out_unit
    output logic [3:0]  m_tuser,   // [2:0] status, [3] run_last
    output logic        m_tlast    // string_done
);
    import utx_pkg::*;

    logic       q_full, push, pop, head_valid;
    job_t       wr_job, head;
    logic [1:0] dst_encoding;

    utx_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .q_full       (q_full),
        .push         (push),
        .job          (wr_job),
        .dst_encoding (dst_encoding)
    );

    // decouples decode from the unit-by-unit expansion of jobs
    utx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_job     (wr_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    utx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dst_encoding (dst_encoding),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

[verif/unicode_transcoder_top_tb.sv]
// unicode_transcoder_top_tb: self-checking bench for the streaming UTF transcoder.
// Depends on utx_pkg and unicode_transcoder_top. A built-in predictor is checked
// against every output transaction, with random stalls on both streams.
module unicode_transcoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utx_pkg::*;

    localparam int LONG_HOLD   = 200;   // cycles the sink holds off once
    localparam int DRAIN_WAIT  = 20;    // cycles after the last result before a cfg write
    localparam int ITEMS_PHASE = 32;    // minimum source units queued per random phase

    // one destination transaction as the bench sees it
    typedef struct packed {
        logic [31:0] unit;
        logic [2:0]  status;
        logic        run_last;
        logic        done;
    } unit_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_SRC;
    logic [1:0]  cfg_data = 2'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;     // [31:0] out_unit
    logic [3:0]  m_tuser;     // [2:0] status, [3] run_last
    logic        m_tlast;     // string_done

    unicode_transcoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: configuration mirror plus the partial decode state.
    // Reset values match the block's reset.
    // ------------------------------------------------------------------
    logic [1:0]  cfg_src    = ENC_UTF8;
    logic [1:0]  cfg_dst    = ENC_UTF8;
    logic        cfg_strict = 1'b0;
    logic [20:0] u8_acc     = '0;
    logic [1:0]  u8_left    = '0;
    logic [2:0]  u8_len     = '0;
    logic [9:0]  sur_bits   = '0;
    logic        sur_pend   = 1'b0;
    logic        str_abort  = 1'b0;

    unit_res_t step_res[$];        // results of the unit being predicted
    bit        step_fail;
    unit_res_t expected_units[$];  // predicted transactions not yet seen on m_*
    logic [32:0] src_items[$];     // {eos, code_unit} waiting for the driver
    int        bad_results = 0;
    bit        quiet = 1'b0;       // no idle cycles on either side
    logic      hold_req = 1'b0;    // ask the sink for its one long hold-off
    logic      hold_done;
    int        hold_left;
    int        sink_gap;
    int        src_gap;

    function void clear_partial();
        u8_acc   = '0;
        u8_left  = '0;
        u8_len   = '0;
        sur_bits = '0;
        sur_pend = 1'b0;
    endfunction

    function void put_unit(logic [31:0] u, logic [2:0] st);
        unit_res_t r;
        if (step_res.size() < 4)
        begin
            r.unit     = u;
            r.status   = st;
            r.run_last = 1'b0;
            r.done     = 1'b0;
            step_res.push_back(r);
        end
    endfunction

    // strict mode: one error transaction replaces whatever this unit produced
    function void raise_err(logic [2:0] code);
        if (!step_fail)
        begin
            step_res.delete();
            put_unit(32'd0, code);
            step_fail = 1'b1;
        end
    endfunction

    function void encode_cp(logic [31:0] cp);
        if (step_fail)
            return;
        case (cfg_dst)
            ENC_ASCII:
            begin
                if (cp > 32'h7F)
                begin
                    if (cfg_strict)
                        raise_err(ST_UNENC);
                    else
                        put_unit(32'(SUBST_CP), ST_OK);
                end
                else
                    put_unit(cp, ST_OK);
            end
            ENC_UTF8:
            begin
                if (cp < 32'h80)
                    put_unit(cp, ST_OK);
                else if (cp < 32'h800)
                begin
                    put_unit(32'hC0 | (cp >> 6), ST_OK);
                    put_unit(32'h80 | (cp & 32'h3F), ST_OK);
                end
                else if (cp < 32'h10000)
                begin
                    put_unit(32'hE0 | (cp >> 12), ST_OK);
                    put_unit(32'h80 | ((cp >> 6) & 32'h3F), ST_OK);
                    put_unit(32'h80 | (cp & 32'h3F), ST_OK);
                end
                else
                begin
                    put_unit(32'hF0 | ((cp >> 18) & 32'h07), ST_OK);
                    put_unit(32'h80 | ((cp >> 12) & 32'h3F), ST_OK);
                    put_unit(32'h80 | ((cp >> 6) & 32'h3F), ST_OK);
                    put_unit(32'h80 | (cp & 32'h3F), ST_OK);
                end
            end
            ENC_UTF16:
            begin
                if (cp > 32'hFFFF)
                begin
                    put_unit(((cp >> 10) + 32'hD7C0) & 32'hFFFF, ST_OK);
                    put_unit((cp & 32'h3FF) + 32'hDC00, ST_OK);
                end
                else
                    put_unit(cp, ST_OK);
            end
            default:
                put_unit(cp, ST_OK);
        endcase
    endfunction

    // malformed input: '?' in substitute mode, error in strict mode
    function void flag_bad(logic [2:0] code);
        if (cfg_strict)
            raise_err(code);
        else
            encode_cp(32'(SUBST_CP));
    endfunction

    function bit cp_ok(logic [31:0] cp);
        return cp <= 32'h10FFFF && (cp < 32'hD800 || cp > 32'hDFFF);
    endfunction

    function void u8_lead(logic [7:0] b);
        if (b < 8'h80)
            encode_cp({24'd0, b});
        else if ((b & 8'hE0) == 8'hC0)
        begin
            u8_acc  = {16'd0, b[4:0]};
            u8_left = 2'd1;
            u8_len  = 3'd2;
        end
        else if ((b & 8'hF0) == 8'hE0)
        begin
            u8_acc  = {17'd0, b[3:0]};
            u8_left = 2'd2;
            u8_len  = 3'd3;
        end
        else if ((b & 8'hF8) == 8'hF0)
        begin
            u8_acc  = {18'd0, b[2:0]};
            u8_left = 2'd3;
            u8_len  = 3'd4;
        end
        else
            flag_bad(ST_BAD_UTF8);  // stray continuation or 0xF8..0xFF: consumed
    endfunction

    function void u8_byte(logic [7:0] b);
        logic [31:0] cp;
        logic [31:0] lim;
        if (u8_left == 2'd0)
            u8_lead(b);
        else if ((b & 8'hC0) == 8'h80)
        begin
            u8_acc  = {u8_acc[14:0], b[5:0]};
            u8_left = u8_left - 2'd1;
            if (u8_left == 2'd0)
            begin
                cp  = {11'd0, u8_acc};
                lim = (u8_len == 3'd2) ? 32'h80 : (u8_len == 3'd3) ? 32'h800 : 32'h10000;
                u8_acc = '0;
                u8_len = '0;
                if (!cp_ok(cp) || cp < lim)
                    flag_bad(ST_BAD_UTF8);   // overlong, surrogate or out of range
                else
                    encode_cp(cp);
            end
        end
        else
        begin
            // sequence broken: '?' then the byte starts over as a lead
            u8_acc  = '0;
            u8_left = '0;
            u8_len  = '0;
            flag_bad(ST_BAD_UTF8);
            if (!step_fail)
                u8_lead(b);
        end
    endfunction

    function void u16_first(logic [15:0] u);
        if (u >= 16'hD800 && u <= 16'hDBFF)
        begin
            sur_bits = u[9:0];
            sur_pend = 1'b1;
        end
        else if (u >= 16'hDC00 && u <= 16'hDFFF)
            flag_bad(ST_BAD_UTF16);          // lone trail
        else
            encode_cp({16'd0, u});
    endfunction

    function void u16_unit(logic [15:0] u);
        logic [31:0] cp;
        if (!sur_pend)
            u16_first(u);
        else if (u >= 16'hDC00 && u <= 16'hDFFF)
        begin
            cp = 32'h10000 + {12'd0, sur_bits, u[9:0]};
            sur_pend = 1'b0;
            sur_bits = '0;
            encode_cp(cp);
        end
        else
        begin
            // lead without trail: '?' and the unit is decoded again
            sur_pend = 1'b0;
            sur_bits = '0;
            flag_bad(ST_BAD_UTF16);
            if (!step_fail)
                u16_first(u);
        end
    endfunction

    // Predict the transactions caused by one accepted source unit.
    function void transcode_unit(logic [31:0] unit, logic eos);
        unit_res_t r;
        step_res.delete();
        step_fail = 1'b0;
        if (str_abort)
        begin
            // aborted string: drop everything, the end-of-string unit included
            if (eos)
                str_abort = 1'b0;
            return;
        end
        case (cfg_src)
            ENC_ASCII:
            begin
                if (unit[7])
                    flag_bad(ST_BAD_ASCII);
                else
                    encode_cp({24'd0, unit[7:0]});
            end
            ENC_UTF8:
            begin
                u8_byte(unit[7:0]);
                if (eos && !step_fail && u8_left != 2'd0)
                begin
                    clear_partial();
                    flag_bad(ST_BAD_UTF8);   // string cut inside a sequence
                end
            end
            ENC_UTF16:
            begin
                u16_unit(unit[15:0]);
                if (eos && !step_fail && sur_pend)
                begin
                    clear_partial();
                    flag_bad(ST_BAD_UTF16);  // string ends after a lead surrogate
                end
            end
            default:
            begin
                if (cp_ok(unit))
                    encode_cp(unit);
                else
                    flag_bad(ST_BAD_UTF32);
            end
        endcase
        if (step_fail)
        begin
            clear_partial();
            if (!eos)
                str_abort = 1'b1;
        end
        if (eos)
            clear_partial();
        if (step_res.size() > 0)
        begin
            r = step_res.pop_back();
            r.run_last = 1'b1;
            r.done     = eos || step_fail;
            step_res.push_back(r);
        end
        foreach (step_res[i])
            expected_units.push_back(step_res[i]);
    endfunction

    // mostly back-to-back, sometimes a short gap, rarely a long one
    function int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function void note_error(string msg);
        bad_results++;
        if (bad_results <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Source driver: one transaction per src_items entry. Prediction runs
    // at the edge where the transaction is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : src_drive
        logic [32:0] nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 32'd0;
            s_tlast  <= 1'b0;
            src_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                transcode_unit(s_tdata, s_tlast);
            if (s_tvalid && !s_tready)
                ;   // hold the offered unit until it is taken
            else if (src_gap != 0)
            begin
                src_gap  <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (src_items.size() != 0)
            begin
                nxt = src_items.pop_front();
                s_tdata  <= nxt[31:0];
                s_tlast  <= nxt[32];
                s_tvalid <= 1'b1;
                src_gap  <= idle_gap();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sink ready: random gaps after transactions, plus one long hold-off on
    // request so the job queue fills and s_tready drops.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : sink_ready
        int g;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            sink_gap  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (sink_gap != 0)
        begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            g = idle_gap();
            m_tready <= (g == 0);
            sink_gap <= (g == 0) ? 0 : g - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: every output transaction against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : out_check
        unit_res_t want;
        unit_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.unit     = m_tdata;
            got.status   = m_tuser[2:0];
            got.run_last = m_tuser[3];
            got.done     = m_tlast;
            if (expected_units.size() == 0)
                note_error($sformatf("unexpected transaction unit=%h status=%0d last=%b done=%b",
                                     got.unit, got.status, got.run_last, got.done));
            else
            begin
                want = expected_units.pop_front();
                if (got != want)
                    note_error($sformatf(
                        "exp unit=%h status=%0d last=%b done=%b, got unit=%h status=%0d last=%b done=%b",
                        want.unit, want.status, want.run_last, want.done,
                        got.unit, got.status, got.run_last, got.done));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function void push_item(logic [31:0] unit, logic eos);
        src_items.push_back({eos, unit});
    endfunction

    // register write at one edge; predictor follows (any write clears partial state)
    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SRC:    cfg_src = val;
            CFG_DST:    cfg_dst = val;
            CFG_STRICT: cfg_strict = val[0];
            default:    ;
        endcase
        clear_partial();
    endtask

    task automatic set_config(logic [1:0] src, logic [1:0] dst, logic strict);
        write_reg(CFG_SRC, src);
        write_reg(CFG_DST, dst);
        write_reg(CFG_STRICT, {1'b0, strict});
    endtask

    // sender stays quiet until every prediction is matched, then the block
    // may finish units that produce nothing during the DRAIN_WAIT delay
    task automatic wait_idle();
        do
            @(negedge clk);
        while (src_items.size() != 0 || s_tvalid || expected_units.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function logic [31:0] rand_cp();
        logic [31:0] cp;
        case ($urandom_range(0, 3))
            0:       cp = $urandom_range(0, 'h7F);
            1:       cp = $urandom_range('h80, 'h7FF);
            2:       cp = $urandom_range('h800, 'hFFFF);
            default: cp = $urandom_range('h10000, 'h10FFFF);
        endcase
        if (cp >= 32'hD800 && cp <= 32'hDFFF)
            cp = cp ^ 32'h2000;
        return cp;
    endfunction

    // One string in the given source encoding: mostly well-formed characters,
    // the rest malformed units, cut sequences, overlongs and surrogates.
    // Ignored upper bits of narrow units are filled at random now and then.
    function void gen_string(logic [1:0] enc, int n_cp);
        logic [31:0] units[$];
        logic [31:0] cp;
        logic [31:0] noise;
        int r;
        for (int c = 0; c < n_cp; c++)
        begin
            cp = rand_cp();
            r  = $urandom_range(0, 99);
            case (enc)
                ENC_ASCII:
                    units.push_back(r < 80 ? (cp & 32'h7F) : 32'($urandom_range(0, 255)));
                ENC_UTF8:
                begin
                    if (r < 89)
                    begin
                        if (cp < 32'h80)
                            units.push_back(cp);
                        else if (cp < 32'h800)
                        begin
                            units.push_back(32'hC0 | (cp >> 6));
                            units.push_back(32'h80 | (cp & 32'h3F));
                        end
                        else if (cp < 32'h10000)
                        begin
                            units.push_back(32'hE0 | (cp >> 12));
                            units.push_back(32'h80 | ((cp >> 6) & 32'h3F));
                            units.push_back(32'h80 | (cp & 32'h3F));
                        end
                        else
                        begin
                            units.push_back(32'hF0 | (cp >> 18));
                            units.push_back(32'h80 | ((cp >> 12) & 32'h3F));
                            units.push_back(32'h80 | ((cp >> 6) & 32'h3F));
                            units.push_back(32'h80 | (cp & 32'h3F));
                        end
                        // cut the sequence short
                        if (r >= 85 && cp >= 32'h80)
                            void'(units.pop_back());
                    end
                    else if (r < 93)
                    begin
                        units.push_back(32'hC0 | ((cp & 32'h7F) >> 6));   // overlong
                        units.push_back(32'h80 | (cp & 32'h3F));
                    end
                    else if (r < 96)
                    begin
                        units.push_back(32'hED);                           // surrogate
                        units.push_back($urandom_range('hA0, 'hBF));
                        units.push_back($urandom_range('h80, 'hBF));
                    end
                    else
                        units.push_back($urandom_range(0, 255));
                end
                ENC_UTF16:
                begin
                    if (r < 85)
                    begin
                        if (cp > 32'hFFFF)
                        begin
                            units.push_back(((cp >> 10) + 32'hD7C0) & 32'hFFFF);
                            units.push_back((cp & 32'h3FF) + 32'hDC00);
                        end
                        else
                            units.push_back(cp);
                    end
                    else if (r < 90)
                        units.push_back($urandom_range('hD800, 'hDBFF));
                    else if (r < 95)
                        units.push_back($urandom_range('hDC00, 'hDFFF));
                    else
                        units.push_back($urandom_range(0, 'hFFFF));
                end
                default:
                begin
                    if (r < 85)
                        units.push_back(cp);
                    else if (r < 90)
                        units.push_back($urandom_range('hD800, 'hDFFF));
                    else if (r < 95)
                        units.push_back(32'h110000 + $urandom_range(0, 'hFFFF));
                    else
                        units.push_back($urandom());
                end
            endcase
        end
        foreach (units[i])
        begin
            noise = $urandom();
            if ($urandom_range(0, 3) == 0)
            begin
                if (enc == ENC_UTF16)
                    units[i] = units[i] | (noise & 32'hFFFF0000);
                else if (enc != ENC_UTF32)
                    units[i] = units[i] | (noise & 32'hFFFFFF00);
            end
            push_item(units[i], i == units.size() - 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : run_test
        int queued;
        logic [1:0] p_src;
        logic [1:0] p_dst;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // UTF-8 -> UTF-16, substitute: 4-byte char to a pair, bad lead,
        // broken sequence, overlong, string cut inside a sequence
        set_config(ENC_UTF8, ENC_UTF16, 1'b0);
        push_item(32'hF0, 1'b0);
        push_item(32'h9F, 1'b0);
        push_item(32'h98, 1'b0);
        push_item(32'h80, 1'b0);
        push_item(32'hFF, 1'b0);
        push_item(32'hE2, 1'b0);
        push_item(32'h41, 1'b0);
        push_item(32'hC0, 1'b0);
        push_item(32'h80, 1'b0);
        push_item(32'hE2, 1'b0);
        push_item(32'h82, 1'b1);
        wait_idle();

        // UTF-16 -> ASCII, strict: broken pair aborts the string, the end
        // clears it; unencodable char on an end-of-string unit
        set_config(ENC_UTF16, ENC_ASCII, 1'b1);
        push_item(32'hD83D, 1'b0);
        push_item(32'h0041, 1'b0);
        push_item(32'h0000, 1'b1);
        push_item(32'h00E9, 1'b1);
        wait_idle();

        // UTF-32 -> UTF-8, substitute: invalid word, top code point, surrogate
        set_config(ENC_UTF32, ENC_UTF8, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'h0010_FFFF, 1'b0);
        push_item(32'h0000_DC00, 1'b1);
        wait_idle();

        // ASCII -> UTF-32, strict: upper bits ignored, high bit is an error
        set_config(ENC_ASCII, ENC_UTF32, 1'b1);
        push_item(32'hFFFF_FF41, 1'b0);
        push_item(32'h0000_0080, 1'b0);
        push_item(32'h0000_007F, 1'b1);
        wait_idle();

        // UTF-16 -> UTF-32, substitute: lone trail, string ends on a lead
        set_config(ENC_UTF16, ENC_UTF32, 1'b0);
        push_item(32'hDC00, 1'b0);
        push_item(32'hD800, 1'b1);
        wait_idle();

        // Random phases over every src/dst pair, strict mode = p[0] ^ p[2].
        // Phase 5 runs without idle cycles; phase 13 (UTF-32 -> UTF-8, up to
        // four bytes per unit) also has the sink hold off for a long stretch
        // while the source keeps offering, so the job queue backs up.
        for (int p = 0; p < 16; p++)
        begin
            p_src = p[3:2];
            p_dst = p[1:0];
            set_config(p_src, p_dst, p[0] ^ p[2]);
            quiet = (p == 5 || p == 13);
            if (p == 13)
            begin
                @(posedge clk);
                hold_req <= 1'b1;
            end
            queued = 0;
            while (queued < ITEMS_PHASE)
            begin
                gen_string(p_src, $urandom_range(1, 6));
                queued = src_items.size();
            end
            wait_idle();
            quiet = 1'b0;
        end

        if (bad_results == 0 && expected_units.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (every unit four results,
    // every gap at its longest, one long hold-off).
    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
rtl/utx_pkg.sv
rtl/utx_front.sv
rtl/utx_queue.sv
rtl/utx_back.sv
rtl/unicode_transcoder_top.sv
verif/unicode_transcoder_top_tb.sv
